[hdl/ctn_pkg.sv]
// Shared types and codes for the complex tracking notch.
// Used by the sequencer, the multiply-accumulate unit and the top level.
package ctn_pkg;

  // operand selects, multiplier side A
  localparam logic [2:0] A_SR = 3'd0;
  localparam logic [2:0] A_SI = 3'd1;
  localparam logic [2:0] A_BW = 3'd2;
  localparam logic [2:0] A_CR = 3'd3;
  localparam logic [2:0] A_CI = 3'd4;
  localparam logic [2:0] A_PR = 3'd5;
  localparam logic [2:0] A_PI = 3'd6;

  // operand selects, multiplier side B
  localparam logic [2:0] B_PR  = 3'd0;
  localparam logic [2:0] B_PI  = 3'd1;
  localparam logic [2:0] B_RLR = 3'd2;
  localparam logic [2:0] B_RHR = 3'd3;
  localparam logic [2:0] B_RLI = 3'd4;
  localparam logic [2:0] B_RHI = 3'd5;
  localparam logic [2:0] B_STR = 3'd6;
  localparam logic [2:0] B_STI = 3'd7;

  // accumulator capture codes
  localparam logic [3:0] CAP_NONE = 4'd0;
  localparam logic [3:0] CAP_RR   = 4'd1;
  localparam logic [3:0] CAP_RI   = 4'd2;
  localparam logic [3:0] CAP_DCR  = 4'd3;
  localparam logic [3:0] CAP_DCI  = 4'd4;
  localparam logic [3:0] CAP_YR   = 4'd5;
  localparam logic [3:0] CAP_YI   = 4'd6;
  localparam logic [3:0] CAP_PR   = 4'd7;
  localparam logic [3:0] CAP_FIN  = 4'd8;

  typedef struct packed {
    logic valid;
    logic clr;
    logic sub;
    logic sh20;
  } mac_op_t;

  typedef struct packed {
    mac_op_t    op;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic [3:0] cap;
  } ctl_t;

endpackage

[hdl/ctn_mac.sv]
// Shared 32x32 signed multiplier with a registered product and a 64-bit accumulator.
// Depends on ctn_pkg for the operation struct.
module ctn_mac import ctn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mac_op_t            op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] acc
);

  logic signed [63:0] prod;
  mac_op_t            pop;
  logic signed [63:0] term;
  logic signed [63:0] base;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop <= '0;
    end else begin
      pop <= op;
    end
    prod <= a * b;
  end

  assign term = pop.sh20 ? (prod <<< 20) : prod;
  assign base = pop.clr ? 64'sd0 : acc;

  always_ff @(posedge clk) begin
    if (pop.valid) begin
      acc <= pop.sub ? (base - term) : (base + term);
    end
  end

endmodule

[hdl/ctn_seq.sv]
// Step sequencer: issues the products of one sample to the shared unit in order.
// Depends on ctn_pkg for the control struct and codes.
module ctn_seq import ctn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic out_free,
  output logic busy,
  output ctl_t ctl
);

  localparam logic [4:0] LAST_STEP = 5'd17;

  logic [4:0] step;
  ctl_t       dec;

  always_comb begin
    dec = '0;
    unique case (step)
      5'd0:  begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_SR; dec.b_sel = B_PR; end
      5'd1:  begin dec.op = '{1'b1, 1'b0, 1'b0, 1'b0}; dec.a_sel = A_SI; dec.b_sel = B_PI; end
      5'd2:  begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_SI; dec.b_sel = B_PR; end
      5'd3:  begin
        dec.op = '{1'b1, 1'b0, 1'b1, 1'b0}; dec.a_sel = A_SR; dec.b_sel = B_PI;
        dec.cap = CAP_RR;
      end
      5'd4:  begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_BW; dec.b_sel = B_RLR; end
      5'd5:  begin
        dec.op = '{1'b1, 1'b0, 1'b0, 1'b1}; dec.a_sel = A_BW; dec.b_sel = B_RHR;
        dec.cap = CAP_RI;
      end
      5'd6:  begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_CR; dec.b_sel = B_PR; end
      5'd7:  begin
        dec.op = '{1'b1, 1'b0, 1'b1, 1'b0}; dec.a_sel = A_CI; dec.b_sel = B_PI;
        dec.cap = CAP_DCR;
      end
      5'd8:  begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_BW; dec.b_sel = B_RLI; end
      5'd9:  begin
        dec.op = '{1'b1, 1'b0, 1'b0, 1'b1}; dec.a_sel = A_BW; dec.b_sel = B_RHI;
        dec.cap = CAP_YR;
      end
      5'd10: begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_CR; dec.b_sel = B_PI; end
      5'd11: begin
        dec.op = '{1'b1, 1'b0, 1'b0, 1'b0}; dec.a_sel = A_CI; dec.b_sel = B_PR;
        dec.cap = CAP_DCI;
      end
      5'd12: begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_PR; dec.b_sel = B_STR; end
      5'd13: begin
        dec.op = '{1'b1, 1'b0, 1'b1, 1'b0}; dec.a_sel = A_PI; dec.b_sel = B_STI;
        dec.cap = CAP_YI;
      end
      5'd14: begin dec.op = '{1'b1, 1'b1, 1'b0, 1'b0}; dec.a_sel = A_PR; dec.b_sel = B_STI; end
      5'd15: begin
        dec.op = '{1'b1, 1'b0, 1'b0, 1'b0}; dec.a_sel = A_PI; dec.b_sel = B_STR;
        dec.cap = CAP_PR;
      end
      5'd17: begin dec.cap = out_free ? CAP_FIN : CAP_NONE; end
      default: begin dec = '0; end
    endcase
  end

  assign ctl = busy ? dec : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end
    end else if (step == LAST_STEP) begin
      if (out_free) begin
        busy <= 1'b0;
      end
    end else begin
      step <= step + 5'd1;
    end
  end

endmodule

[hdl/complex_tracking_notch.sv]
// Complex tracking notch, top level: state, operand selection, rounding and output beat.
// Depends on ctn_pkg, ctn_seq and ctn_mac.
//
// Input beats on s_axis carry one complex Q1.15 sample; output beats on m_axis carry
// the filtered sample. Each input beat spins the sample down by the running phasor,
// removes and updates the tracked DC estimate, spins the residual back up and then
// advances the phasor by the step phasor held in the configuration registers.
// The cfg channel writes step_real (index 0), step_imag (1) and notch_bandwidth (2);
// it is always ready, and writes are meant for idle periods only.
// While a sample is in flight, from acceptance until the output beat is loaded,
// s_axis_tready is low; a new beat can be taken once the output beat has been loaded,
// so samples are not overlapped. The sequencer issues sixteen products, one per cycle,
// to the single shared multiplier, whose two-stage product and accumulate pipeline
// registers each product before it reaches the accumulator.
// A result waits in the output register while m_axis_tready is low; the next sample
// may be accepted meanwhile but stalls at its final step until that beat is taken.
// Synchronous reset sets the phasor to unity, clears the DC estimate, restores the
// default registers and drops any pending beat.
module complex_tracking_notch import ctn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample_real [15:0], sample_imag [31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_real [15:0], out_imag [31:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] REG_STEP_REAL = 2'd0;
  localparam logic [1:0] REG_STEP_IMAG = 2'd1;
  localparam logic [1:0] REG_BANDWIDTH = 2'd2;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [63:0] DC_MAX  = 64'sd549755813887;
  localparam logic signed [63:0] DC_MIN  = -64'sd549755813888;
  localparam logic signed [63:0] PH_LIM  = 64'sd2147483647;
  localparam logic signed [63:0] Y_MAX   = 64'sd32767;
  localparam logic signed [63:0] Y_MIN   = -64'sd32768;
  localparam logic signed [39:0] UP_LIM  = 40'sd1073741823;

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    if (v > DC_MAX) return DC_MAX[39:0];
    if (v < DC_MIN) return DC_MIN[39:0];
    return v[39:0];
  endfunction

  function automatic logic signed [31:0] sat_ph(input logic signed [63:0] v);
    if (v > PH_LIM) return PH_LIM[31:0];
    if (v < -PH_LIM) return 32'(-PH_LIM);
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    if (v > Y_MAX) return Y_MAX[15:0];
    if (v < Y_MIN) return Y_MIN[15:0];
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat_up(input logic signed [39:0] v);
    if (v > UP_LIM) return UP_LIM[31:0];
    if (v < -UP_LIM) return 32'(-UP_LIM);
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clamp_step(input logic signed [31:0] v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  logic signed [31:0] step_real;
  logic signed [31:0] step_imag;
  logic        [15:0] notch_bandwidth;
  logic signed [31:0] phasor_real;
  logic signed [31:0] phasor_imag;
  logic signed [39:0] dc_real;
  logic signed [39:0] dc_imag;
  logic signed [15:0] sample_real;
  logic signed [15:0] sample_imag;
  logic signed [39:0] res_real;
  logic signed [39:0] res_imag;
  logic signed [15:0] y_real;
  logic signed [15:0] y_imag;

  logic               busy;
  logic               accept;
  logic               out_free;
  ctl_t               ctl;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] acc;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic        [5:0]  shamt;
  logic signed [63:0] half;
  logic signed [63:0] rnd_val;

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready     = 1'b1;

  ctn_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  assign cr = sat_up(res_real);
  assign ci = sat_up(res_imag);

  always_comb begin
    unique case (ctl.a_sel)
      A_SR:    op_a = 32'(sample_real);
      A_SI:    op_a = 32'(sample_imag);
      A_BW:    op_a = {16'd0, notch_bandwidth};
      A_CR:    op_a = cr;
      A_CI:    op_a = ci;
      A_PR:    op_a = phasor_real;
      A_PI:    op_a = phasor_imag;
      default: op_a = '0;
    endcase
    unique case (ctl.b_sel)
      B_PR:    op_b = phasor_real;
      B_PI:    op_b = phasor_imag;
      B_RLR:   op_b = {12'd0, res_real[19:0]};
      B_RHR:   op_b = 32'($signed(res_real[39:20]));
      B_RLI:   op_b = {12'd0, res_imag[19:0]};
      B_RHI:   op_b = 32'($signed(res_imag[39:20]));
      B_STR:   op_b = step_real;
      B_STI:   op_b = step_imag;
      default: op_b = '0;
    endcase
  end

  ctn_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (ctl.op),
    .a   (op_a),
    .b   (op_b),
    .acc (acc)
  );

  always_comb begin
    unique case (ctl.cap) inside
      CAP_RR, CAP_RI:   shamt = 6'd21;
      CAP_DCR, CAP_DCI: shamt = 6'd16;
      CAP_YR, CAP_YI:   shamt = 6'd39;
      CAP_PR, CAP_FIN:  shamt = 6'd30;
      default:          shamt = 6'd1;
    endcase
  end

  assign half    = 64'sd1 <<< (shamt - 6'd1);
  assign rnd_val = (acc + half) >>> shamt;

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_real <= s_axis_tdata[15:0];
      sample_imag <= s_axis_tdata[31:16];
    end
    case (ctl.cap)
      CAP_RR: res_real <= sat40(rnd_val - 64'(dc_real));
      CAP_RI: res_imag <= sat40(rnd_val - 64'(dc_imag));
      CAP_YR: y_real   <= sat16(rnd_val);
      CAP_YI: y_imag   <= sat16(rnd_val);
      CAP_FIN: m_axis_tdata <= {y_imag, y_real};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_real       <= ONE_Q30;
      step_imag       <= '0;
      notch_bandwidth <= '0;
      phasor_real     <= ONE_Q30;
      phasor_imag     <= '0;
      dc_real         <= '0;
      dc_imag         <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_STEP_REAL: step_real       <= clamp_step(cfg_data);
          REG_STEP_IMAG: step_imag       <= clamp_step(cfg_data);
          REG_BANDWIDTH: notch_bandwidth <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (ctl.cap)
        CAP_DCR: dc_real     <= sat40(64'(dc_real) + rnd_val);
        CAP_DCI: dc_imag     <= sat40(64'(dc_imag) + rnd_val);
        CAP_PR:  phasor_real <= sat_ph(rnd_val);
        CAP_FIN: phasor_imag <= sat_ph(rnd_val);
        default: ;
      endcase
      if (ctl.cap == CAP_FIN) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule
